### rtl/bdq_pkg.sv
// shared types, constants and ring arithmetic for the bounded deque
// no dependencies; imported by bdq_store, bdq_ctrl and the top level
package bdq_pkg;

	localparam int CAPACITY    = 32;
	localparam int VALUE_WIDTH = 32;

	localparam int IDX_W       = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int SUM_W       = CNT_W + 1;
	localparam int MODE_W      = 3;
	localparam int STATUS_W    = 2;
	localparam int PORT_VAL_W  = 32;
	localparam int COUNT_OUT_W = 6;

	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DELETE     = 3'd4;
	localparam logic [MODE_W-1:0] MODE_DUMP       = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

	typedef logic [IDX_W-1:0]              idx_t;
	typedef logic [CNT_W-1:0]              cnt_t;
	typedef logic signed [VALUE_WIDTH-1:0] val_t;

	typedef struct packed {
		logic we;
		idx_t waddr;
		val_t wdata;
		logic re;
		idx_t raddr;
	} mem_req_t;

	typedef struct packed {
		logic                valid;
		val_t                value;
		logic [STATUS_W-1:0] status;
		logic                last;
		cnt_t                count;
	} res_t;

	function automatic idx_t ring_inc(input idx_t a);
		return (a == IDX_W'(CAPACITY - 1)) ? '0 : idx_t'(a + 1'b1);
	endfunction

	function automatic idx_t ring_dec(input idx_t a);
		return (a == '0) ? IDX_W'(CAPACITY - 1) : idx_t'(a - 1'b1);
	endfunction

	// a < CAPACITY and b <= CAPACITY, so one conditional subtract wraps it
	function automatic idx_t ring_add(input idx_t a, input cnt_t b);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(a) + SUM_W'(b);
		if (sum >= SUM_W'(CAPACITY)) begin
			sum = sum - SUM_W'(CAPACITY);
		end
		return IDX_W'(sum);
	endfunction

endpackage

### rtl/bounded_deque_with_delete_by_value.sv
// Bounded deque of up to CAPACITY signed entries with push/pop at both ends,
// delete of the first entry equal to a value, and a front-to-back dump. One
// operation is taken at a time; in_stall is high from acceptance until its
// last result beat has been loaded into the output register. For delete-by-value
// the ring store is read one entry per cycle to search, and once the value is hit
// each later entry is written back one slot forward as the same walk goes on.
// A dump gives one beat per entry, slowed only by out_stall.
// The store needs no clearing pass after reset; only written slots are ever read.
// depends on bdq_pkg, bdq_store, bdq_ctrl
module bounded_deque_with_delete_by_value (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_valid,
	output logic                                       in_stall,
	input  logic [bdq_pkg::MODE_W-1:0]                 mode,
	input  logic signed [bdq_pkg::PORT_VAL_W-1:0]      value,
	output logic                                       out_valid,
	input  logic                                       out_stall,
	output logic signed [bdq_pkg::PORT_VAL_W-1:0]      value_out,
	output logic [bdq_pkg::STATUS_W-1:0]               status,
	output logic                                       last,
	output logic [bdq_pkg::COUNT_OUT_W-1:0]            count_out
);
	import bdq_pkg::*;

	mem_req_t            mem_req;
	val_t                rd_data;
	res_t                res;
	logic                out_free;
	logic                out_valid_q;
	val_t                out_value_q;
	logic [STATUS_W-1:0] out_status_q;
	logic                out_last_q;
	cnt_t                out_count_q;

	bdq_store u_store (
		.clk     (clk),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

	bdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.value    (value),
		.out_free (out_free),
		.mem_req  (mem_req),
		.rd_data  (rd_data),
		.res      (res)
	);

	// output register parts the sequencer from the downstream stall
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_value_q  <= res.value;
			out_status_q <= res.status;
			out_last_q   <= res.last;
			out_count_q  <= res.count;
		end
	end

	assign out_valid = out_valid_q;
	assign value_out = PORT_VAL_W'(out_value_q);
	assign status    = out_status_q;
	assign last      = out_last_q;
	assign count_out = COUNT_OUT_W'(out_count_q);

endmodule

### rtl/bdq_store.sv
// ring store of deque entries: one write port, one registered read port
// depends on bdq_pkg
module bdq_store (
	input  logic               clk,
	input  bdq_pkg::mem_req_t  mem_req,
	output bdq_pkg::val_t      rd_data
);
	import bdq_pkg::*;

	val_t mem_q [CAPACITY];
	val_t rd_data_q;

	// read data holds while no read is issued, so a stalled dump keeps its entry
	always_ff @(posedge clk) begin
		if (mem_req.we) begin
			mem_q[mem_req.waddr] <= mem_req.wdata;
		end
		if (mem_req.re) begin
			rd_data_q <= mem_q[mem_req.raddr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/bdq_ctrl.sv
// operation sequencer: front/count pointers, scan/shift/dump walks, one compare unit
// depends on bdq_pkg; drives bdq_store through a mem_req_t
module bdq_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [bdq_pkg::MODE_W-1:0]        mode,
	input  logic signed [bdq_pkg::PORT_VAL_W-1:0] value,
	input  logic                              out_free,
	output bdq_pkg::mem_req_t                 mem_req,
	input  bdq_pkg::val_t                     rd_data,
	output bdq_pkg::res_t                     res
);
	import bdq_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_POPW  = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_SHIFT = 3'd4;
	localparam logic [2:0] S_DUMP  = 3'd5;
	localparam logic [2:0] S_EMIT  = 3'd6;

	logic [2:0]          state_q, state_d;
	logic [MODE_W-1:0]   mode_q, mode_d;
	val_t                value_q, value_d;
	idx_t                front_q, front_d;
	cnt_t                count_q, count_d;
	idx_t                rd_slot_q, rd_slot_d;
	idx_t                wr_slot_q, wr_slot_d;
	cnt_t                left_q, left_d;
	val_t                res_val_q, res_val_d;
	logic [STATUS_W-1:0] res_status_q, res_status_d;

	logic accept;
	logic empty;
	logic full;
	logic match;
	idx_t tail_slot;
	idx_t nxt_slot;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign empty    = (count_q == '0);
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign match    = (rd_data == value_q);
	assign nxt_slot = ring_inc(rd_slot_q);
	// pop back needs the last entry, push back the slot after it
	assign tail_slot = ring_add(front_q,
		(mode_q == MODE_POP_BACK) ? cnt_t'(count_q - 1'b1) : count_q);

	always_comb begin
		state_d      = state_q;
		mode_d       = mode_q;
		value_d      = value_q;
		front_d      = front_q;
		count_d      = count_q;
		rd_slot_d    = rd_slot_q;
		wr_slot_d    = wr_slot_q;
		left_d       = left_q;
		res_val_d    = res_val_q;
		res_status_d = res_status_q;
		mem_req      = '0;
		res          = '0;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					mode_d  = mode;
					value_d = VALUE_WIDTH'(value);
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				res_val_d    = '0;
				res_status_d = ST_OK;
				state_d      = S_EMIT;
				unique case (mode_q)
					MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
						if (full) begin
							res_status_d = ST_FULL;
						end else begin
							mem_req.we    = 1'b1;
							mem_req.wdata = value_q;
							if (mode_q == MODE_PUSH_FRONT) begin
								mem_req.waddr = ring_dec(front_q);
								front_d       = ring_dec(front_q);
							end else begin
								mem_req.waddr = tail_slot;
							end
							count_d = cnt_t'(count_q + 1'b1);
						end
					end
					MODE_POP_FRONT, MODE_POP_BACK: begin
						if (empty) begin
							res_status_d = ST_EMPTY;
						end else begin
							mem_req.re    = 1'b1;
							mem_req.raddr = (mode_q == MODE_POP_FRONT) ? front_q : tail_slot;
							state_d       = S_POPW;
						end
					end
					MODE_DELETE, MODE_DUMP: begin
						if (empty) begin
							res_status_d = ST_EMPTY;
						end else begin
							mem_req.re    = 1'b1;
							mem_req.raddr = front_q;
							rd_slot_d     = front_q;
							left_d        = cnt_t'(count_q - 1'b1);
							state_d       = (mode_q == MODE_DELETE) ? S_SCAN : S_DUMP;
						end
					end
					default: begin
						res_status_d = ST_OK;
					end
				endcase
			end
			S_POPW: begin
				res_val_d = rd_data;
				count_d   = cnt_t'(count_q - 1'b1);
				if (mode_q == MODE_POP_FRONT) begin
					front_d = ring_inc(front_q);
				end
				state_d = S_EMIT;
			end
			S_SCAN: begin
				if (match) begin
					res_val_d = rd_data;
					wr_slot_d = rd_slot_q;
					if (left_q == '0) begin
						count_d = cnt_t'(count_q - 1'b1);
						state_d = S_EMIT;
					end else begin
						mem_req.re    = 1'b1;
						mem_req.raddr = nxt_slot;
						rd_slot_d     = nxt_slot;
						left_d        = cnt_t'(left_q - 1'b1);
						state_d       = S_SHIFT;
					end
				end else if (left_q == '0) begin
					res_val_d    = '0;
					res_status_d = ST_NOT_FOUND;
					state_d      = S_EMIT;
				end else begin
					mem_req.re    = 1'b1;
					mem_req.raddr = nxt_slot;
					rd_slot_d     = nxt_slot;
					left_d        = cnt_t'(left_q - 1'b1);
				end
			end
			S_SHIFT: begin
				// close the gap: each entry behind the hit moves one slot forward
				mem_req.we    = 1'b1;
				mem_req.waddr = wr_slot_q;
				mem_req.wdata = rd_data;
				wr_slot_d     = rd_slot_q;
				if (left_q == '0) begin
					count_d = cnt_t'(count_q - 1'b1);
					state_d = S_EMIT;
				end else begin
					mem_req.re    = 1'b1;
					mem_req.raddr = nxt_slot;
					rd_slot_d     = nxt_slot;
					left_d        = cnt_t'(left_q - 1'b1);
				end
			end
			S_DUMP: begin
				if (out_free) begin
					res.valid  = 1'b1;
					res.value  = rd_data;
					res.status = ST_OK;
					res.last   = (left_q == '0);
					res.count  = count_q;
					if (left_q == '0) begin
						state_d = S_IDLE;
					end else begin
						mem_req.re    = 1'b1;
						mem_req.raddr = nxt_slot;
						rd_slot_d     = nxt_slot;
						left_d        = cnt_t'(left_q - 1'b1);
					end
				end
			end
			S_EMIT: begin
				if (out_free) begin
					res.valid  = 1'b1;
					res.value  = res_val_q;
					res.status = res_status_q;
					res.last   = 1'b1;
					res.count  = count_q;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			front_q <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		mode_q       <= mode_d;
		value_q      <= value_d;
		rd_slot_q    <= rd_slot_d;
		wr_slot_q    <= wr_slot_d;
		left_q       <= left_d;
		res_val_q    <= res_val_d;
		res_status_q <= res_status_d;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> out_free)
		else $error("result beat issued while output register busy");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_req.we)
		else $error("store written while idle");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EXEC))
		else $error("accepted beat not executed");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && mem_req.we) |=> (count_q == cnt_t'($past(count_q) + 1'b1)))
		else $error("push did not grow the count");

endmodule
